// File: rtl/v3alu_pkg.sv
// v3alu_pkg: shared constants and operation codes for the vec3 fixed-point alu
// used by the channel interfaces and by the top level, no dependencies

package v3alu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int OP_BITS   = 4;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_ADDS  = 4'd4,
    OP_SUBS  = 4'd5,
    OP_SSUB  = 4'd6,
    OP_MULS  = 4'd7,
    OP_DIVS  = 4'd8,
    OP_SDIV  = 4'd9,
    OP_NEG   = 4'd10,
    OP_DOT   = 4'd11,
    OP_LENSQ = 4'd12,
    OP_LEN   = 4'd13,
    OP_NORM  = 4'd14,
    OP_CROSS = 4'd15
  } op_t;

endpackage

// File: rtl/v3alu_if.sv
// v3alu_in_if / v3alu_out_if: valid-ready channels for request and result beats
// depends on v3alu_pkg for the default word width and opcode width

interface v3alu_in_if #(
  parameter int WORD_BITS = v3alu_pkg::WORD_BITS
);
  logic                                 valid;
  logic                                 ready;
  logic [v3alu_pkg::OP_BITS-1:0]        req_type;
  logic signed [WORD_BITS-1:0]          ax;
  logic signed [WORD_BITS-1:0]          ay;
  logic signed [WORD_BITS-1:0]          az;
  logic signed [WORD_BITS-1:0]          bx;
  logic signed [WORD_BITS-1:0]          by;
  logic signed [WORD_BITS-1:0]          bz;
  logic signed [WORD_BITS-1:0]          scalar_in;

  modport source (output valid, req_type, ax, ay, az, bx, by, bz, scalar_in, input ready);
  modport sink   (input valid, req_type, ax, ay, az, bx, by, bz, scalar_in, output ready);
endinterface

interface v3alu_out_if #(
  parameter int WORD_BITS = v3alu_pkg::WORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] rx;
  logic signed [WORD_BITS-1:0] ry;
  logic signed [WORD_BITS-1:0] rz;
  logic signed [WORD_BITS-1:0] scalar_out;
  logic                        divide_by_zero;
  logic                        saturated;

  modport source (output valid, rx, ry, rz, scalar_out, divide_by_zero, saturated, input ready);
  modport sink   (input valid, rx, ry, rz, scalar_out, divide_by_zero, saturated, output ready);
endinterface

// File: rtl/vec3_fixed_point_alu_unit.sv
// vec3_fixed_point_alu_unit: pipelined three-component fixed-point vector alu
// depends on v3alu_pkg and the channel interfaces in v3alu_if.sv

// One request beat per clock enters and one result beat per clock leaves.
// Every opcode alike takes the same path (Q16.16 by default): four front
// stages register the inputs, form the products, sum them and clamp; then a
// square-root chain resolves two root bits per stage and three division lanes
// resolve two quotient bits per stage; a last stage clamps quotients into the
// output register. When the output beat is not taken the whole pipe holds.

module vec3_fixed_point_alu_unit #(
  parameter int WORD_BITS = v3alu_pkg::WORD_BITS,
  parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  v3alu_in_if.sink    in_ch,
  v3alu_out_if.source out_ch
);

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int WW    = 2 * W + 2;
  localparam int QW    = W + F;
  localparam int STEPS = 2;
  localparam int NSQ   = (W + STEPS - 1) / STEPS;
  localparam int NDV   = (QW + STEPS - 1) / STEPS;
  localparam int LAST  = NSQ + NDV;

  typedef logic [W-1:0]         word_t;
  typedef logic signed [WW-1:0] wide_t;

  localparam word_t MAXW    = {1'b0, {(W-1){1'b1}}};
  localparam word_t MINW    = {1'b1, {(W-1){1'b0}}};
  localparam wide_t WMAX_X  = {{(WW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam wide_t WMIN_X  = {{(WW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam wide_t FR_BIAS = {{(WW-F){1'b0}}, {F{1'b1}}};
  localparam wide_t ZERO_X  = '0;
  localparam logic [QW-1:0] LIM_P = {{(F+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [QW-1:0] LIM_N = {{F{1'b0}}, 1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    v3alu_pkg::op_t op;
    word_t [2:0]    a;
    word_t [2:0]    b;
    word_t          s;
  } s1_t;

  typedef struct packed {
    v3alu_pkg::op_t        op;
    word_t [2:0]           a;
    word_t [2:0]           b;
    word_t                 s;
    logic [2:0][2*W-1:0]   p;
    logic [2:0][2*W-1:0]   q;
  } s2_t;

  typedef struct packed {
    v3alu_pkg::op_t op;
    word_t [2:0]    a;
    word_t [2:0]    b;
    word_t          s;
    wide_t [2:0]    wv;
    logic           shf;
    wide_t          ssum;
  } s3_t;

  typedef struct packed {
    v3alu_pkg::op_t     op;
    word_t [2:0]        r;
    word_t              sc;
    logic               sat;
    logic               dzf;
    logic [2:0]         dv;
    logic [2:0]         qneg;
    word_t [2:0]        dm;
    logic [2:0][QW-1:0] nq;
    word_t [2:0]        drem;
    logic [2*W-1:0]     srem;
    word_t              sres;
  } pl_t;

  typedef struct packed {
    word_t [2:0] r;
    word_t       sc;
    logic        dz;
    logic        sat;
  } res_t;

  function automatic logic [W:0] fin_f(input wide_t v, input logic shf);
    wide_t      t;
    logic [W:0] res;
    if (shf) begin
      t = (v + (v[WW-1] ? FR_BIAS : ZERO_X)) >>> F;
    end else begin
      t = v;
    end
    if (t > WMAX_X) begin
      res = {1'b1, MAXW};
    end else if (t < WMIN_X) begin
      res = {1'b1, MINW};
    end else begin
      res = {1'b0, t[W-1:0]};
    end
    return res;
  endfunction

  function automatic word_t mag_f(input word_t v);
    return v[W-1] ? word_t'(-v) : v;
  endfunction

  logic en;
  logic v1_r, v2_r, v3_r;
  logic [LAST:0] vld_r;
  logic out_valid_r;

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  pl_t  st_r   [LAST+1];
  pl_t  st_nxt [LAST+1];
  pl_t  dv_in;
  res_t out_r, out_nxt;

  // the whole pipe moves whenever the output slot is free or being emptied
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_ch.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      vld_r       <= {vld_r[LAST-1:0], v3_r};
      out_valid_r <= vld_r[LAST];
    end
  end

  // stage 1: input register
  always_comb begin
    s1_nxt.op   = v3alu_pkg::op_t'(in_ch.req_type);
    s1_nxt.a[0] = in_ch.ax;
    s1_nxt.a[1] = in_ch.ay;
    s1_nxt.a[2] = in_ch.az;
    s1_nxt.b[0] = in_ch.bx;
    s1_nxt.b[1] = in_ch.by;
    s1_nxt.b[2] = in_ch.bz;
    s1_nxt.s    = in_ch.scalar_in;
  end

  // stage 2: two full-width products per lane
  always_comb begin
    int                  j;
    int                  k;
    word_t               x;
    word_t               y;
    logic signed [2*W-1:0] pp;
    logic signed [2*W-1:0] qq;
    s2_nxt.op = s1_r.op;
    s2_nxt.a  = s1_r.a;
    s2_nxt.b  = s1_r.b;
    s2_nxt.s  = s1_r.s;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      x = (s1_r.op == v3alu_pkg::OP_CROSS) ? s1_r.a[j] : s1_r.a[i];
      unique case (s1_r.op)
        v3alu_pkg::OP_MULS:  y = s1_r.s;
        v3alu_pkg::OP_LENSQ,
        v3alu_pkg::OP_LEN,
        v3alu_pkg::OP_NORM:  y = s1_r.a[i];
        v3alu_pkg::OP_CROSS: y = s1_r.b[k];
        default:             y = s1_r.b[i];
      endcase
      pp = $signed(x) * $signed(y);
      qq = $signed(s1_r.a[k]) * $signed(s1_r.b[j]);
      s2_nxt.p[i] = pp;
      s2_nxt.q[i] = qq;
    end
  end

  // stage 3: wide per-lane values and the three-term sum
  always_comb begin
    wide_t wa;
    wide_t wb;
    wide_t ws;
    wide_t pi;
    wide_t qi;
    s3_nxt.op = s2_r.op;
    s3_nxt.a  = s2_r.a;
    s3_nxt.b  = s2_r.b;
    s3_nxt.s  = s2_r.s;
    ws        = WW'($signed(s2_r.s));
    for (int i = 0; i < 3; i++) begin
      wa = WW'($signed(s2_r.a[i]));
      wb = WW'($signed(s2_r.b[i]));
      pi = WW'($signed(s2_r.p[i]));
      qi = WW'($signed(s2_r.q[i]));
      unique case (s2_r.op)
        v3alu_pkg::OP_ADD:   s3_nxt.wv[i] = wa + wb;
        v3alu_pkg::OP_SUB:   s3_nxt.wv[i] = wa - wb;
        v3alu_pkg::OP_ADDS:  s3_nxt.wv[i] = wa + ws;
        v3alu_pkg::OP_SUBS:  s3_nxt.wv[i] = wa - ws;
        v3alu_pkg::OP_SSUB:  s3_nxt.wv[i] = ws - wa;
        v3alu_pkg::OP_NEG:   s3_nxt.wv[i] = ZERO_X - wa;
        v3alu_pkg::OP_MUL,
        v3alu_pkg::OP_MULS:  s3_nxt.wv[i] = pi;
        v3alu_pkg::OP_CROSS: s3_nxt.wv[i] = pi - qi;
        default:             s3_nxt.wv[i] = ZERO_X;
      endcase
    end
    s3_nxt.shf  = (s2_r.op == v3alu_pkg::OP_MUL) || (s2_r.op == v3alu_pkg::OP_MULS) ||
                  (s2_r.op == v3alu_pkg::OP_CROSS);
    s3_nxt.ssum = WW'($signed(s2_r.p[0])) + WW'($signed(s2_r.p[1])) +
                  WW'($signed(s2_r.p[2]));
  end

  // stage 4: clamp, set up divisions and the root radicand
  always_comb begin
    logic [W:0] fr;
    logic [W:0] fs;
    word_t      n;
    word_t      d;
    st_nxt[0]      = '0;
    st_nxt[0].op   = s3_r.op;
    st_nxt[0].srem = s3_r.ssum[2*W-1:0];
    fs             = fin_f(s3_r.ssum, 1'b1);
    if ((s3_r.op == v3alu_pkg::OP_DOT) || (s3_r.op == v3alu_pkg::OP_LENSQ)) begin
      st_nxt[0].sc  = fs[W-1:0];
      st_nxt[0].sat = fs[W];
    end
    for (int i = 0; i < 3; i++) begin
      fr = fin_f(s3_r.wv[i], s3_r.shf);
      unique case (s3_r.op)
        v3alu_pkg::OP_DIVS: begin
          n = s3_r.a[i];
          d = s3_r.s;
        end
        v3alu_pkg::OP_SDIV: begin
          n = s3_r.s;
          d = s3_r.a[i];
        end
        default: begin
          n = s3_r.a[i];
          d = s3_r.b[i];
        end
      endcase
      unique case (s3_r.op)
        v3alu_pkg::OP_DIV,
        v3alu_pkg::OP_DIVS,
        v3alu_pkg::OP_SDIV: begin
          if (d == '0) begin
            st_nxt[0].dzf  = 1'b1;
            st_nxt[0].r[i] = (n == '0) ? '0 : (n[W-1] ? MINW : MAXW);
          end else begin
            st_nxt[0].dv[i]   = 1'b1;
            st_nxt[0].nq[i]   = {mag_f(n), {F{1'b0}}};
            st_nxt[0].dm[i]   = mag_f(d);
            st_nxt[0].qneg[i] = n[W-1] ^ d[W-1];
          end
        end
        v3alu_pkg::OP_NORM: st_nxt[0].r[i] = s3_r.a[i];
        v3alu_pkg::OP_DOT,
        v3alu_pkg::OP_LENSQ,
        v3alu_pkg::OP_LEN:  st_nxt[0].r[i] = '0;
        default: begin
          st_nxt[0].r[i] = fr[W-1:0];
          st_nxt[0].sat  = st_nxt[0].sat | fr[W];
        end
      endcase
    end
  end

  // square root, two result bits per stage
  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    always_comb begin
      int             idx;
      int             bp;
      logic [2*W:0]   tt;
      st_nxt[g+1] = st_r[g];
      for (int k = 0; k < STEPS; k++) begin
        idx = g * STEPS + k;
        if (idx < W) begin
          bp = W - 1 - idx;
          tt = ((2*W+1)'(st_nxt[g+1].sres) << (bp + 1)) | ((2*W+1)'(1) << (2 * bp));
          if ({1'b0, st_nxt[g+1].srem} >= tt) begin
            st_nxt[g+1].srem     = st_nxt[g+1].srem - tt[2*W-1:0];
            st_nxt[g+1].sres[bp] = 1'b1;
          end
        end
      end
    end
  end

  // normalize takes its divisor from the finished root
  always_comb begin
    dv_in = st_r[NSQ];
    if ((dv_in.op == v3alu_pkg::OP_NORM) && (dv_in.sres != '0)) begin
      for (int i = 0; i < 3; i++) begin
        dv_in.dv[i]   = 1'b1;
        dv_in.dm[i]   = dv_in.sres;
        dv_in.nq[i]   = {mag_f(dv_in.r[i]), {F{1'b0}}};
        dv_in.qneg[i] = dv_in.r[i][W-1];
        dv_in.drem[i] = '0;
      end
    end
  end

  // restoring division in three lanes, two quotient bits per stage
  for (genvar g = 0; g < NDV; g++) begin : g_div
    always_comb begin
      int         idx;
      logic [W:0] rem2;
      logic       qb;
      st_nxt[NSQ+g+1] = (g == 0) ? dv_in : st_r[NSQ+g];
      for (int k = 0; k < STEPS; k++) begin
        idx = g * STEPS + k;
        if (idx < QW) begin
          for (int i = 0; i < 3; i++) begin
            rem2 = {st_nxt[NSQ+g+1].drem[i], st_nxt[NSQ+g+1].nq[i][QW-1]};
            qb   = 1'b0;
            if (rem2 >= {1'b0, st_nxt[NSQ+g+1].dm[i]}) begin
              rem2 = rem2 - {1'b0, st_nxt[NSQ+g+1].dm[i]};
              qb   = 1'b1;
            end
            st_nxt[NSQ+g+1].drem[i] = rem2[W-1:0];
            st_nxt[NSQ+g+1].nq[i]   = {st_nxt[NSQ+g+1].nq[i][QW-2:0], qb};
          end
        end
      end
    end
  end

  // last stage: clamp quotients and the length
  always_comb begin
    pl_t            o;
    logic [QW-1:0]  lim;
    o           = st_r[LAST];
    out_nxt.r   = o.r;
    out_nxt.sc  = o.sc;
    out_nxt.dz  = o.dzf;
    out_nxt.sat = o.sat;
    if (o.op == v3alu_pkg::OP_LEN) begin
      if (o.sres[W-1]) begin
        out_nxt.sc  = MAXW;
        out_nxt.sat = 1'b1;
      end else begin
        out_nxt.sc = o.sres;
      end
    end
    for (int i = 0; i < 3; i++) begin
      lim = o.qneg[i] ? LIM_N : LIM_P;
      if (o.dv[i]) begin
        if (o.nq[i] > lim) begin
          out_nxt.sat  = 1'b1;
          out_nxt.r[i] = o.qneg[i] ? MINW : MAXW;
        end else begin
          out_nxt.r[i] = o.qneg[i] ? word_t'(-o.nq[i][W-1:0]) : o.nq[i][W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      out_r <= out_nxt;
      for (int g = 0; g <= LAST; g++) begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.rx             = out_r.r[0];
  assign out_ch.ry             = out_r.r[1];
  assign out_ch.rz             = out_r.r[2];
  assign out_ch.scalar_out     = out_r.sc;
  assign out_ch.divide_by_zero = out_r.dz;
  assign out_ch.saturated      = out_r.sat;

endmodule

// File: tb/vec3_fixed_point_alu_unit_tb.sv
// vec3_fixed_point_alu_unit_tb: self-checking bench for the vec3 fixed-point alu
// drives request beats from a queue, predicts each result and checks it in order
// depends on v3alu_pkg, the channel interfaces and the top level

module vec3_fixed_point_alu_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = v3alu_pkg::WORD_BITS;
  localparam int F = v3alu_pkg::FRAC_BITS;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef logic signed [127:0] wide_t;

  typedef struct {
    v3alu_pkg::op_t      op;
    logic signed [W-1:0] a [3];
    logic signed [W-1:0] b [3];
    logic signed [W-1:0] s;
  } request_t;

  typedef struct {
    logic [W-1:0] r [3];
    logic [W-1:0] sc;
    logic         dz;
    logic         sat;
  } vec_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  v3alu_in_if  #(.WORD_BITS(W)) in_ch ();
  v3alu_out_if #(.WORD_BITS(W)) out_ch ();

  vec3_fixed_point_alu_unit #(.WORD_BITS(W), .FRAC_BITS(F)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t    pending_reqs [$];
  vec_result_t expected_results [$];
  request_t    on_wire;
  int          cycle_no = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          op_hits [16];
  int          dz_hits = 0;
  int          sat_hits = 0;
  bit          stim_done = 1'b0;

  // shift right by sh toward zero, then clamp into the word range
  function automatic logic [W-1:0] clamp_word(input wide_t v, input int sh, inout logic sat);
    logic         neg;
    logic [127:0] m;
    logic [127:0] lim;
    neg = v[127];
    m = neg ? 128'(-v) : 128'(v);
    m = m >> sh;
    lim = neg ? 128'(1) << (W - 1) : (128'(1) << (W - 1)) - 1;
    if (m > lim) begin
      m = lim;
      sat = 1'b1;
    end
    return neg ? W'(-m) : m[W-1:0];
  endfunction

  function automatic logic [W-1:0] fix_div(input wide_t n, input wide_t d,
                                           inout logic dz, inout logic sat);
    logic [127:0] q;
    if (d == 0) begin
      dz = 1'b1;
      if (n == 0) return '0;
      return n[127] ? WMIN : WMAX;
    end
    q = ((n[127] ? 128'(-n) : 128'(n)) << F) / (d[127] ? 128'(-d) : 128'(d));
    if (n[127] ^ d[127]) q = -q;
    return clamp_word(wide_t'(q), 0, sat);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
    logic [127:0] res;
    logic [127:0] c;
    res = '0;
    for (int bitn = 63; bitn >= 0; bitn--) begin
      c = res | (128'(1) << bitn);
      if (c * c <= n) res = c;
    end
    return res[63:0];
  endfunction

  function automatic vec_result_t alu_predict(input request_t q);
    vec_result_t  e;
    wide_t        a [3];
    wide_t        b [3];
    wide_t        s;
    wide_t        acc;
    logic [63:0]  len;
    int           j, k;
    e.r[0] = '0; e.r[1] = '0; e.r[2] = '0; e.sc = '0; e.dz = 1'b0; e.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a[i] = wide_t'(q.a[i]);
      b[i] = wide_t'(q.b[i]);
    end
    s = wide_t'(q.s);
    case (q.op)
      v3alu_pkg::OP_DOT, v3alu_pkg::OP_LENSQ: begin
        acc = 0;
        for (int i = 0; i < 3; i++)
          acc += a[i] * ((q.op == v3alu_pkg::OP_DOT) ? b[i] : a[i]);
        e.sc = clamp_word(acc, F, e.sat);
      end
      v3alu_pkg::OP_LEN, v3alu_pkg::OP_NORM: begin
        acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        len = floor_sqrt(acc);
        if (q.op == v3alu_pkg::OP_LEN) e.sc = clamp_word(wide_t'({64'd0, len}), 0, e.sat);
        else for (int i = 0; i < 3; i++)
          e.r[i] = (len == 0) ? q.a[i]
                              : fix_div(a[i], wide_t'({64'd0, len}), e.dz, e.sat);
      end
      v3alu_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          e.r[i] = clamp_word(a[j] * b[k] - a[k] * b[j], F, e.sat);
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          case (q.op)
            v3alu_pkg::OP_ADD:  e.r[i] = clamp_word(a[i] + b[i], 0, e.sat);
            v3alu_pkg::OP_SUB:  e.r[i] = clamp_word(a[i] - b[i], 0, e.sat);
            v3alu_pkg::OP_MUL:  e.r[i] = clamp_word(a[i] * b[i], F, e.sat);
            v3alu_pkg::OP_DIV:  e.r[i] = fix_div(a[i], b[i], e.dz, e.sat);
            v3alu_pkg::OP_ADDS: e.r[i] = clamp_word(a[i] + s, 0, e.sat);
            v3alu_pkg::OP_SUBS: e.r[i] = clamp_word(a[i] - s, 0, e.sat);
            v3alu_pkg::OP_SSUB: e.r[i] = clamp_word(s - a[i], 0, e.sat);
            v3alu_pkg::OP_MULS: e.r[i] = clamp_word(a[i] * s, F, e.sat);
            v3alu_pkg::OP_DIVS: e.r[i] = fix_div(a[i], s, e.dz, e.sat);
            v3alu_pkg::OP_SDIV: e.r[i] = fix_div(s, a[i], e.dz, e.sat);
            default:            e.r[i] = clamp_word(-a[i], 0, e.sat);
          endcase
        end
      end
    endcase
    return e;
  endfunction

  function automatic logic signed [W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return WMAX;
      2:       return WMIN;
      3, 4:    return W'($signed($urandom()) >>> 12);
      5:       return W'($signed($urandom()) >>> 20);
      default: return W'($urandom());
    endcase
  endfunction

  function automatic request_t make_req(input v3alu_pkg::op_t op,
                                        input logic signed [W-1:0] av,
                                        input logic signed [W-1:0] bv,
                                        input logic signed [W-1:0] sv);
    request_t q;
    q.op = op;
    for (int i = 0; i < 3; i++) begin
      q.a[i] = av;
      q.b[i] = bv;
    end
    q.s = sv;
    return q;
  endfunction

  // stimulus: directed corners, then random requests
  initial begin
    request_t q;
    for (int op = 0; op < 16; op++) begin
      q = make_req(v3alu_pkg::op_t'(op), WMAX, WMIN, WMIN);
      q.a[1] = WMIN; q.a[2] = '0; q.b[1] = WMAX; q.b[2] = 32'sh0001_0000;
      pending_reqs.push_back(q);
    end
    // divide by zero with positive, negative and zero dividends
    q = make_req(v3alu_pkg::OP_DIV, 32'sh0003_0000, '0, '0);
    q.a[1] = -32'sh0002_0000; q.a[2] = '0;
    pending_reqs.push_back(q);
    q.op = v3alu_pkg::OP_DIVS;
    pending_reqs.push_back(q);
    pending_reqs.push_back(make_req(v3alu_pkg::OP_SDIV, '0, '0, WMIN));
    // normalise of a zero vector passes it through
    pending_reqs.push_back(make_req(v3alu_pkg::OP_NORM, '0, WMAX, WMAX));
    pending_reqs.push_back(make_req(v3alu_pkg::OP_NEG, WMIN, '0, '0));
    pending_reqs.push_back(make_req(v3alu_pkg::OP_LEN, WMIN, '0, '0));
    pending_reqs.push_back(make_req(v3alu_pkg::OP_MUL, -32'sh0000_8001, 32'sh0000_8000, '0));
    pending_reqs.push_back(make_req(v3alu_pkg::OP_NORM, 32'sh0000_0001, '0, '0));
    for (int n = 0; n < 1100; n++) begin
      q.op = v3alu_pkg::op_t'($urandom_range(15));
      for (int i = 0; i < 3; i++) begin
        q.a[i] = pick_word();
        q.b[i] = pick_word();
      end
      q.s = pick_word();
      pending_reqs.push_back(q);
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // quiet stretch with no idling on either side
  function automatic bit take_break();
    if (cycle_no > 1500 && cycle_no < 2500) return 1'b0;
    return $urandom_range(99) < 23;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(alu_predict(on_wire));
        op_hits[on_wire.op]++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() > 0 && !take_break()) begin
          on_wire = pending_reqs.pop_front();
          in_ch.req_type <= on_wire.op;
          in_ch.ax <= on_wire.a[0]; in_ch.ay <= on_wire.a[1]; in_ch.az <= on_wire.a[2];
          in_ch.bx <= on_wire.b[0]; in_ch.by <= on_wire.b[1]; in_ch.bz <= on_wire.b[2];
          in_ch.scalar_in <= on_wire.s;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
          if (pending_reqs.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    vec_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycle_no);
        end else begin
          e = expected_results.pop_front();
          dz_hits += e.dz;
          sat_hits += e.sat;
          if (out_ch.rx !== e.r[0] || out_ch.ry !== e.r[1] || out_ch.rz !== e.r[2] ||
              out_ch.scalar_out !== e.sc || out_ch.divide_by_zero !== e.dz ||
              out_ch.saturated !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch beat %0d: exp %h %h %h sc %h dz %b sat %b,",
                        " got %h %h %h sc %h dz %b sat %b"},
                       results_seen, e.r[0], e.r[1], e.r[2], e.sc, e.dz, e.sat,
                       out_ch.rx, out_ch.ry, out_ch.rz, out_ch.scalar_out,
                       out_ch.divide_by_zero, out_ch.saturated);
          end
        end
      end
      out_ch.ready <= !take_break();
    end
  end

  initial begin
    int ops_covered;
    wait (stim_done && rst_n);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;
    ops_covered = 0;
    for (int i = 0; i < 16; i++) if (op_hits[i] > 0) ops_covered++;
    $display("checked %0d result beats over %0d of 16 opcodes", results_seen, ops_covered);
    $display("%0d beats flagged divide by zero, %0d saturated", dz_hits, sat_hits);
    if (mismatches == 0) begin
      $display("PASS vec3_fixed_point_alu_unit");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL vec3_fixed_point_alu_unit");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("FAIL vec3_fixed_point_alu_unit");
    $finish;
  end

endmodule
